// File: design/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg - shared types for the double-ended queue with search
// Action and status codes, per-cell operation codes and the cell control
// bundle that the top level broadcasts along the cell chain.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_CONTAINS   = 3'd4,
        ACT_REMOVE     = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_PUSH_BACK,
        CELL_POP_FRONT,
        CELL_POP_BACK,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [DATA_W-1:0]  value;
    } cell_ctl_t;

endpackage

// File: design/double_ended_queue_with_search_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_with_search_unit - bounded deque with search and remove
// Chain of CAPACITY cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries an action and a 32-bit value:
//   push front, push back, pop front, pop back, contains, remove first match.
//   Output channel (out_valid/out_ready) returns one result per input
//   transfer: status, found flag, front and back values and the count.
//   The result is registered and shows in the cycle after the input transfer.
//   One item is taken per cycle while the receiver keeps up; the cell chain
//   shifts and closes gaps and the search ripples a match bit through the cells.
//   The result sits in an output register; a new item is accepted while that
//   register is empty or being drained in the same cycle, so a stalled
//   receiver holds the input side after one pending result.
//   Reset clears the occupied flags and the count, leaving the queue empty
//   and the output register empty; stored values themselves are not cleared.
//   Pushes into a full queue report full, pops on an empty one report empty,
//   and neither changes the store.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search_unit #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [2:0]                            action,
    input  logic signed [deq_pkg::DATA_W-1:0]     value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [1:0]                            status,
    output logic                                  found,
    output logic signed [deq_pkg::DATA_W-1:0]     front_value,
    output logic signed [deq_pkg::DATA_W-1:0]     back_value,
    output logic [$clog2(CAPACITY+1)-1:0]         count
);
    import deq_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic              accept;
    logic              is_full;
    logic              is_empty;
    action_t           act;
    cell_ctl_t         ctl;
    status_t           status_next;
    logic              found_next;
    logic              hit;
    logic [CNT_W-1:0]  count_next;
    logic [DATA_W-1:0] front_next;
    logic [DATA_W-1:0] back_next;

    logic [CAPACITY-1:0] occ;
    logic [CAPACITY-1:0] occ_nx;
    logic [CAPACITY-1:0] seen;
    logic [CAPACITY-1:0] last_nx;
    logic [DATA_W-1:0]   val    [CAPACITY];
    logic [DATA_W-1:0]   val_nx [CAPACITY];

    logic              out_valid_reg;
    status_t           status_reg;
    logic              found_reg;
    logic [DATA_W-1:0] front_reg;
    logic [DATA_W-1:0] back_reg;
    logic [CNT_W-1:0]  count_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign act      = action_t'(action);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign hit      = seen[CAPACITY-1];

    // Decode the action into a chain operation and the result fields
    always_comb
    begin
        ctl.op      = CELL_HOLD;
        ctl.value   = value;
        status_next = ST_DONE;
        found_next  = 1'b0;
        count_next  = count_reg;
        unique case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctl.op     = (act == ACT_PUSH_FRONT) ? CELL_PUSH_FRONT : CELL_PUSH_BACK;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    ctl.op     = (act == ACT_POP_FRONT) ? CELL_POP_FRONT : CELL_POP_BACK;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ACT_CONTAINS:
            begin
                found_next = hit;
            end
            ACT_REMOVE:
            begin
                found_next = hit;
                if (hit)
                begin
                    ctl.op     = CELL_REMOVE;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                found_next = 1'b0;
            end
        endcase
        if (!accept)
        begin
            ctl.op = CELL_HOLD;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_W-1:0] lv;
            logic              lo;
            logic [DATA_W-1:0] rv;
            logic              ro;
            logic              si;

            if (gi == 0)
            begin : g_head
                assign lv = value;
                assign lo = 1'b1;
                assign si = 1'b0;
            end
            else
            begin : g_mid
                assign lv = val[gi-1];
                assign lo = occ[gi-1];
                assign si = seen[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign rv = '0;
                assign ro = 1'b0;
            end
            else
            begin : g_inner
                assign rv = val[gi+1];
                assign ro = occ[gi+1];
            end

            deq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .left_val  (lv),
                .left_occ  (lo),
                .right_val (rv),
                .right_occ (ro),
                .seen_in   (si),
                .cell_val  (val[gi]),
                .cell_occ  (occ[gi]),
                .val_next  (val_nx[gi]),
                .occ_next  (occ_nx[gi]),
                .seen_out  (seen[gi])
            );
        end
    endgenerate

    // Front is cell zero; back is the last occupied cell after the step
    assign last_nx    = occ_nx & ~{1'b0, occ_nx[CAPACITY-1:1]};
    assign front_next = occ_nx[0] ? val_nx[0] : '0;

    always_comb
    begin
        back_next = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            back_next = back_next | (val_nx[i] & {DATA_W{last_nx[i]}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
            front_reg  <= front_next;
            back_reg   <= back_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign front_value = front_reg;
    assign back_value  = back_reg;
    assign count       = count_reg;

    // The occupied flags always match the count
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ) == 32'(count_reg))
        else $error("occupied cells disagree with count");

    // Occupied cells are packed toward the front
    a_occ_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (occ & ~{occ[CAPACITY-2:0], 1'b1}) == '0)
        else $error("gap in occupied cells");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_full && (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK)
        |=> count_reg == $past(count_reg) && status_reg == ST_FULL)
        else $error("push into full queue changed the store");

    a_remove_hit: assert property (@(posedge clk) disable iff (!rst_n)
        accept && act == ACT_REMOVE && hit
        |=> count_reg == $past(count_reg) - CNT_W'(1) && found_reg)
        else $error("remove with a match did not shrink the queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count above capacity");

endmodule

// File: design/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell - one storage slot of the queue chain
// Holds one value and an occupied flag, compares against the broadcast value
// and takes data from its left or right neighbor or the broadcast value as asked.
// ----------------------------------------------------------------------------
module deq_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  deq_pkg::cell_ctl_t       ctl,
    input  logic [deq_pkg::DATA_W-1:0] left_val,
    input  logic                     left_occ,
    input  logic [deq_pkg::DATA_W-1:0] right_val,
    input  logic                     right_occ,
    input  logic                     seen_in,
    output logic [deq_pkg::DATA_W-1:0] cell_val,
    output logic                     cell_occ,
    output logic [deq_pkg::DATA_W-1:0] val_next,
    output logic                     occ_next,
    output logic                     seen_out
);
    import deq_pkg::*;

    logic [DATA_W-1:0] val_reg;
    logic              occ_reg;
    logic              match;

    always_comb
    begin
        match    = occ_reg && (val_reg == ctl.value);
        seen_out = seen_in | match;
        val_next = val_reg;
        occ_next = occ_reg;
        unique case (ctl.op)
            CELL_HOLD:
            begin
                val_next = val_reg;
            end
            CELL_PUSH_FRONT:
            begin
                val_next = left_val;
                occ_next = left_occ;
            end
            CELL_PUSH_BACK:
            begin
                // first free slot takes the new value
                if (!occ_reg && left_occ)
                begin
                    val_next = ctl.value;
                    occ_next = 1'b1;
                end
            end
            CELL_POP_FRONT:
            begin
                val_next = right_val;
                occ_next = right_occ;
            end
            CELL_POP_BACK:
            begin
                if (!right_occ)
                begin
                    occ_next = 1'b0;
                end
            end
            CELL_REMOVE:
            begin
                // close the gap from the first match onward
                if (seen_out)
                begin
                    val_next = right_val;
                    occ_next = right_occ;
                end
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    assign cell_val = val_reg;
    assign cell_occ = occ_reg;

endmodule
